### design/arw_pkg.sv
// shared types and constants of the anti-replay window
// no dependencies; arw_if, arw_update and anti_replay_window import this package
package arw_pkg;

	localparam int SeqW     = 64;
	localparam int WinBits  = 256;
	localparam int IdxW     = $clog2(WinBits);
	localparam int DistW    = $clog2(WinBits + 1);
	localparam int WinDepth = 1;

	localparam logic [1:0] ActRecord = 2'd0;
	localparam logic [1:0] ActCheck  = 2'd1;
	localparam logic [1:0] ActClear  = 2'd2;

	typedef enum logic [2:0] {
		DispAccepted  = 3'd0,
		DispDuplicate = 3'd1,
		DispTooOld    = 3'd2,
		DispFuture    = 3'd3,
		DispInvalid   = 3'd4
	} disp_t;

	// bit n of bits means top - n was accepted
	typedef struct packed {
		logic [SeqW-1:0]    top;
		logic [WinBits-1:0] bits;
	} win_t;

	localparam int StW = $bits(win_t);

	typedef struct packed {
		logic [1:0]      action;
		logic [SeqW-1:0] seq;
	} req_t;

	typedef struct packed {
		disp_t disp;
		logic  write;
		win_t  next;
	} upd_t;

endpackage

### design/arw_if.sv
// valid/ready channels of the anti-replay window: request and response
// depends on arw_pkg
interface arw_req_if import arw_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      action;
	logic [SeqW-1:0] sequence_req;

	modport source (output valid, action, sequence_req, input ready);
	modport sink   (input valid, action, sequence_req, output ready);
endinterface

interface arw_rsp_if import arw_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [2:0]      disposition;
	logic [SeqW-1:0] window_top;

	modport source (output valid, disposition, window_top, input ready);
	modport sink   (input valid, disposition, window_top, output ready);
endinterface

### design/arw_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module arw_ram #(
	parameter int Width = 8,
	parameter int Depth = 2,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### design/arw_update.sv
// classification of one sequence number and the next window contents
// depends on arw_pkg
module arw_update import arw_pkg::*; (
	input  win_t cur,
	input  req_t req,
	output upd_t upd
);
	logic [SeqW:0]    up_diff;
	logic [SeqW-1:0]  jump;
	logic [SeqW-1:0]  off;
	logic [SeqW-1:0]  win_lim;
	logic             newer;
	logic             empty;
	disp_t            disp;
	win_t             rec;
	logic             write;

	assign up_diff = {1'b0, req.seq} - {1'b0, cur.top};
	assign jump    = up_diff[SeqW-1:0];
	assign off     = cur.top - req.seq;
	assign win_lim = SeqW'(WinBits);
	assign newer   = !up_diff[SeqW] && (jump != '0);
	assign empty   = (cur.top == '0);

	always_comb begin
		disp = DispAccepted;
		rec  = cur;
		if (req.action == ActClear) begin
			rec = '0;
		end else if (req.seq == '0) begin
			disp = DispInvalid;
		end else if (empty) begin
			if (req.seq > win_lim) begin
				disp = DispFuture;
			end
			rec.top  = req.seq;
			rec.bits = WinBits'(1);
		end else if (newer) begin
			if (jump > win_lim) begin
				disp = DispFuture;
			end
			// a step of the full window size shifts every old bit out
			rec.top  = req.seq;
			rec.bits = (cur.bits << jump[DistW-1:0]) | WinBits'(1);
		end else if (off >= win_lim) begin
			disp = DispTooOld;
		end else if (cur.bits[off[IdxW-1:0]]) begin
			disp = DispDuplicate;
		end else begin
			rec.bits = cur.bits | (WinBits'(1) << off[IdxW-1:0]);
		end
	end

	assign write = (req.action == ActClear) ||
		((req.action == ActRecord) && (disp == DispAccepted));

	assign upd.disp  = disp;
	assign upd.write = write;
	assign upd.next  = write ? rec : cur;
endmodule

### design/anti_replay_window.sv
// Anti-replay sliding window: checks packet sequence numbers against the
// highest accepted number and a bitmap of accepted numbers below it.
// req channel: action (record, check only, clear) and sequence_req.
// rsp channel: disposition and window_top after the step.
// One response per request, in order. The window state is read from a
// one-entry ram at the req transfer, classified and updated in the update
// stage, and the response sits in an output register.
// A new request is taken every cycle while rsp does not stall; the write
// of one item and the read of the next share an edge, so the state just
// written is forwarded from a register instead of the ram.
// The state update (64-bit compare, 256-bit barrel shift) sets the cycle.
// After reset the window is empty; the ram is not reset, a valid flag
// makes the unwritten entry read as empty.
// When rsp stalls, one item waits in the update stage and one in the output
// register, and req.ready drops until the output register frees up.
// Depends on arw_pkg, arw_if, arw_ram and arw_update.
module anti_replay_window import arw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	arw_req_if.sink    req,
	arw_rsp_if.source  rsp
);
	logic      acc;
	logic      out_free;
	logic      s1_go;
	logic      we;
	logic      v_s1;
	req_t      req_s1;
	logic      fwd_s1;
	logic      init_s1;
	logic      init_q;
	win_t      st_q;
	win_t      ram_rd;
	win_t      cur;
	upd_t      upd;
	logic      out_v_q;
	disp_t     out_disp_q;
	logic [SeqW-1:0] out_top_q;

	assign out_free  = !out_v_q || rsp.ready;
	assign s1_go     = v_s1 && out_free;
	assign req.ready = !v_s1 || out_free;
	assign acc       = req.valid && req.ready;
	assign we        = s1_go && upd.write;

	arw_ram #(
		.Width(StW),
		.Depth(WinDepth)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr ('0),
		.wdata (upd.next),
		.re    (acc),
		.raddr ('0),
		.rdata (ram_rd)
	);

	// forwarded copy wins when the write landed on the read edge
	assign cur = fwd_s1 ? st_q : (init_s1 ? ram_rd : '0);

	arw_update u_update (
		.cur (cur),
		.req (req_s1),
		.upd (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_s1  <= 1'b0;
			init_s1 <= 1'b0;
			init_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1    <= 1'b1;
				fwd_s1  <= we;
				init_s1 <= init_q;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (we) begin
				init_q <= 1'b1;
			end
			if (s1_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= '{action: req.action, seq: req.sequence_req};
		end
		if (we) begin
			st_q <= upd.next;
		end
		if (s1_go) begin
			out_disp_q <= upd.disp;
			out_top_q  <= upd.next.top;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.disposition = out_disp_q;
	assign rsp.window_top  = out_top_q;

`ifndef SYNTH
	a_write_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (upd.disp == DispAccepted))
		else $error("window written for a rejected number");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (req_s1.action == ActClear)) |=> (st_q.top == '0) && (st_q.bits == '0))
		else $error("clear left the window non-empty");

	a_record_marks_top: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (req_s1.action == ActRecord)) |=> (st_q.top != '0) && st_q.bits[0])
		else $error("recorded window lacks its top bit");

	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && we) |=> fwd_s1 && init_q)
		else $error("forwarding not armed on a read-write collision");
`endif
endmodule

### dv/anti_replay_window_tb.sv
// testbench for the anti-replay window: a directed table, then random traffic,
// with every response checked against its typed table row or an in-bench window predictor
// depends on arw_pkg, arw_if and anti_replay_window
`timescale 1ns / 100ps

module anti_replay_window_tb import arw_pkg::*; ();

	// reserved action code, decoded as check only
	localparam logic [1:0] ActUnused = 2'd3;

	localparam logic [SeqW-1:0] SeqMax   = '1;
	localparam logic [SeqW-1:0] WinSpan  = SeqW'(WinBits);
	localparam int              NDir     = 25;
	localparam int              NRand    = 675;
	localparam int              CalmFrom = 350;
	localparam int              CalmTo   = 500;
	localparam int              HoldFrom = 250;
	localparam int              HoldLen  = 80;
	localparam int              FreeFrom = 450;
	localparam int              FreeTo   = 650;
	localparam int              DrainCyc = 4;

	typedef struct packed {
		disp_t           disp;
		logic [SeqW-1:0] top;
	} verdict_t;

	typedef struct packed {
		logic [1:0]      action;
		logic [SeqW-1:0] seq;
		logic            typed;
		disp_t           disp;
		logic [SeqW-1:0] top;
	} dir_row_t;

	// rows with typed = 0 are checked against the predictor
	localparam dir_row_t DirTbl [NDir] = '{
		'{ActCheck,  64'd0,                  1'b1, DispInvalid,   64'd0},
		'{ActRecord, 64'd257,                1'b1, DispFuture,    64'd0},
		'{ActRecord, 64'd256,                1'b1, DispAccepted,  64'd256},
		'{ActRecord, 64'd256,                1'b1, DispDuplicate, 64'd256},
		'{ActRecord, 64'd1,                  1'b0, DispAccepted,  64'd0},
		'{ActRecord, 64'd0,                  1'b1, DispInvalid,   64'd256},
		'{ActCheck,  SeqMax,                 1'b1, DispFuture,    64'd256},
		'{ActRecord, 64'd513,                1'b1, DispFuture,    64'd256},
		'{ActRecord, 64'd512,                1'b0, DispAccepted,  64'd0},
		'{ActRecord, 64'd256,                1'b0, DispAccepted,  64'd0},
		'{ActRecord, 64'd257,                1'b0, DispAccepted,  64'd0},
		'{ActRecord, 64'd1,                  1'b1, DispTooOld,    64'd512},
		'{ActCheck,  64'd300,                1'b0, DispAccepted,  64'd0},
		'{ActRecord, 64'd300,                1'b0, DispAccepted,  64'd0},
		'{ActCheck,  64'd300,                1'b0, DispAccepted,  64'd0},
		'{ActUnused, 64'd600,                1'b0, DispAccepted,  64'd0},
		'{ActUnused, 64'd0,                  1'b1, DispInvalid,   64'd512},
		'{ActRecord, 64'd600,                1'b0, DispAccepted,  64'd0},
		'{ActClear,  SeqMax,                 1'b1, DispAccepted,  64'd0},
		'{ActRecord, SeqMax,                 1'b1, DispFuture,    64'd0},
		'{ActRecord, 64'd1,                  1'b1, DispAccepted,  64'd1},
		'{ActRecord, 64'h8000_0000_0000_0000, 1'b1, DispFuture,   64'd1},
		'{ActRecord, 64'd257,                1'b1, DispAccepted,  64'd257},
		'{ActRecord, 64'd1,                  1'b0, DispAccepted,  64'd0},
		'{ActClear,  64'd0,                  1'b1, DispAccepted,  64'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	arw_req_if req_ch ();
	arw_rsp_if rsp_ch ();

	anti_replay_window DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// predicted window state
	logic [SeqW-1:0]    shadow_top = '0;
	logic [WinBits-1:0] shadow_seen = '0;

	// top as the stimulus side sees it, used only to aim sequence numbers
	logic [SeqW-1:0]    stim_top;

	verdict_t    pending_verdicts [$];
	int unsigned err_cnt = 0;
	int unsigned n_taken = 0;
	int unsigned n_clears = 0;
	int unsigned disp_tally [5] = '{default: 0};

	function automatic verdict_t window_advance(input logic [1:0] act,
			input logic [SeqW-1:0] seq);
		verdict_t        v;
		logic [SeqW-1:0] off;
		v.disp = DispAccepted;
		off = '0;
		if (act == ActClear) begin
			shadow_top = '0;
			shadow_seen = '0;
		end else if (seq == '0) begin
			v.disp = DispInvalid;
		end else begin
			if (shadow_top == '0) begin
				if (seq > WinSpan)
					v.disp = DispFuture;
			end else if (seq > shadow_top) begin
				if (seq - shadow_top > WinSpan)
					v.disp = DispFuture;
			end else begin
				off = shadow_top - seq;
				if (off >= WinSpan)
					v.disp = DispTooOld;
				else if (shadow_seen[off[IdxW-1:0]])
					v.disp = DispDuplicate;
			end
			if (v.disp == DispAccepted && act == ActRecord) begin
				if (shadow_top == '0) begin
					shadow_seen = WinBits'(1);
					shadow_top = seq;
				end else if (seq > shadow_top) begin
					// a shift by the full window leaves only the new top
					shadow_seen = (shadow_seen << (seq - shadow_top)) | WinBits'(1);
					shadow_top = seq;
				end else begin
					shadow_seen[off[IdxW-1:0]] = 1'b1;
				end
			end
		end
		v.top = shadow_top;
		return v;
	endfunction

	function automatic logic [1:0] pick_action();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return ActRecord;
		if (k < 80)
			return ActCheck;
		if (k < 86)
			return ActUnused;
		if (k < 89)
			return ActClear;
		return ActRecord;
	endfunction

	// mostly numbers around the current top so the bitmap gets exercised
	function automatic logic [SeqW-1:0] pick_seq(input logic [SeqW-1:0] top);
		int unsigned     m;
		int unsigned     d;
		logic [SeqW-1:0] b;
		m = $urandom_range(0, 99);
		b = SeqW'($urandom_range(0, 1));
		if (m < 4)
			return '0;
		if (m < 12)
			return {$urandom, $urandom};
		if (m < 20) begin
			if (top > WinSpan && $urandom_range(0, 1) == 1)
				return top - WinSpan + b;
			return top + WinSpan + b;
		end
		if (m < 45) begin
			d = $urandom_range(0, 24);
			return (top > d) ? top - d : SeqW'($urandom_range(1, WinBits));
		end
		if (top == '0)
			return SeqW'($urandom_range(1, WinBits + 20));
		d = $urandom_range(0, 560);
		if (d < 300)
			return (top > 300 - d) ? top - (300 - d) : SeqW'($urandom_range(1, WinBits));
		return top + (d - 300);
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [SeqW-1:0] seq,
			input bit may_idle);
		if (may_idle) begin
			while ($urandom_range(0, 99) < 9) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.sequence_req <= seq;
		if (act == ActClear)
			stim_top = '0;
		else if (act == ActRecord && seq != '0) begin
			if (stim_top == '0 ? seq <= WinSpan : (seq > stim_top && seq - stim_top <= WinSpan))
				stim_top = seq;
		end
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// response check first, then the new request, so one block owns the queue
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("response with nothing outstanding: disposition %0d, window_top %0h",
						rsp_ch.disposition, rsp_ch.window_top);
					err_cnt++;
				end else begin
					v = pending_verdicts.pop_front();
					if (rsp_ch.disposition !== v.disp) begin
						$error("disposition: expected %0d, got %0d", v.disp, rsp_ch.disposition);
						err_cnt++;
					end
					if (rsp_ch.window_top !== v.top) begin
						$error("window_top: expected %0h, got %0h", v.top, rsp_ch.window_top);
						err_cnt++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				v = window_advance(req_ch.action, req_ch.sequence_req);
				if (n_taken < NDir && DirTbl[n_taken].typed) begin
					v.disp = DirTbl[n_taken].disp;
					v.top = DirTbl[n_taken].top;
				end
				if (req_ch.action == ActClear)
					n_clears++;
				disp_tally[v.disp]++;
				n_taken++;
				pending_verdicts.insert(pending_verdicts.size(), v);
			end
		end
	end

	// response side: random back-pressure, one long hold-off, one free stretch
	initial begin : rsp_sink
		int unsigned cyc;
		cyc = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HoldFrom && cyc < HoldFrom + HoldLen)
				rsp_ch.ready <= 1'b0;
			else if (cyc >= FreeFrom && cyc < FreeTo)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 99) >= 9);
		end
	end

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int              i;
		logic [1:0]      act;
		logic [SeqW-1:0] seq;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ActRecord;
		req_ch.sequence_req = '0;
		stim_top = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NDir; i++)
			send_item(DirTbl[i].action, DirTbl[i].seq, 1'b1);

		for (i = 0; i < NRand; i++) begin
			act = pick_action();
			seq = pick_seq(stim_top);
			send_item(act, seq, !(i >= CalmFrom && i < CalmTo));
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DrainCyc) @(posedge clk);

		$display("checked %0d requests including %0d window clears", n_taken, n_clears);
		$display("accepted %0d, duplicate %0d, too old %0d, future jump %0d, zero %0d",
			disp_tally[DispAccepted], disp_tally[DispDuplicate], disp_tally[DispTooOld],
			disp_tally[DispFuture], disp_tally[DispInvalid]);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
